>>> rtl/sws_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sliding window sender.
// No dependencies; used by every rtl file through scoped names.
package sws_pkg;

  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned WIN_W  = 6;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned OUSR_W = 3;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;

  localparam logic [MODE_W-1:0] MODE_CREDIT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ANY    = 2'd1;

  localparam logic [IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_WINDOW = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAMES = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RETIRE,
    ST_MEASURE,
    ST_PLAN,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    OP_STATUS,
    OP_FILL,
    OP_RESEND
  } op_e;

  typedef struct packed {
    logic load;
    logic retire;
    logic measure;
    logic plan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

>>> rtl/sws_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences retire, measure, plan and emit steps.
// Depends on sws_pkg; drives the datapath through cmd_t and reads sts_t.
module sws_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sws_pkg::sts_t sts_i,
  output sws_pkg::cmd_t cmd_o
);

  sws_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sws_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sws_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sws_pkg::ST_RETIRE;
        end
      end
      sws_pkg::ST_RETIRE: begin
        cmd_o.retire = 1'b1;
        state_d      = sws_pkg::ST_MEASURE;
      end
      sws_pkg::ST_MEASURE: begin
        cmd_o.measure = 1'b1;
        state_d       = sws_pkg::ST_PLAN;
      end
      sws_pkg::ST_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d    = sws_pkg::ST_EMIT;
      end
      sws_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = sws_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sws_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/sws_dp.sv
`timescale 1ns / 1ps
// Datapath: config registers, window pointers, burst planning and output register.
// Depends on sws_pkg; steered by sws_ctrl through cmd_t.
module sws_dp #(
  parameter int unsigned WIN_MAX = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sws_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [sws_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic [sws_pkg::KIND_W-1:0]  in_kind_i,
  input  logic [sws_pkg::SEQ_W-1:0]   in_ack_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [sws_pkg::SEQ_W-1:0]   out_seq_o,
  output logic [sws_pkg::OUSR_W-1:0]  out_user_o,
  output logic                        out_last_o,
  input  sws_pkg::cmd_t               cmd_i,
  output sws_pkg::sts_t               sts_o
);

  localparam int unsigned CW = $clog2(WIN_MAX + 1);
  localparam logic [CW-1:0] WM = CW'(WIN_MAX);
  localparam logic [sws_pkg::SEQ_W-1:0] WM32 = sws_pkg::SEQ_W'(WIN_MAX);

  logic [sws_pkg::MODE_W-1:0] mode_q;
  logic [sws_pkg::WIN_W-1:0]  win_q;
  logic [sws_pkg::SEQ_W-1:0]  frames_q;

  logic [sws_pkg::KIND_W-1:0] kind_q;
  logic [sws_pkg::SEQ_W-1:0]  ack_q;

  logic [sws_pkg::SEQ_W-1:0]  base_q, next_q, seq_q;
  logic                       done_q, started_q, upd_q, left_le_q;
  sws_pkg::op_e               op_q;
  logic [CW-1:0]              outst_q, left_sat_q, cnt_q;

  logic                       out_vld_q, out_has_q, out_rs_q, out_fin_q, out_last_q;
  logic [sws_pkg::SEQ_W-1:0]  out_seq_q;

  // combinational helpers
  logic                       cumulative;
  logic [sws_pkg::SEQ_W-1:0]  outst_full, left_full, win32;
  logic [CW-1:0]              w_eff, room, fill_cnt, plan_cnt, emit_inc;
  logic [CW:0]                outst_after;
  logic                       all_sent, done_d;

  assign cumulative = !(mode_q == sws_pkg::MODE_CREDIT || mode_q == sws_pkg::MODE_ANY);
  assign outst_full = next_q - base_q;
  assign left_full  = frames_q - next_q;
  assign win32      = sws_pkg::SEQ_W'(win_q);

  always_comb begin
    if (win_q == '0) begin
      w_eff = CW'(1);
    end else if (win32 > WM32) begin
      w_eff = WM;
    end else begin
      w_eff = win32[CW-1:0];
    end
    room        = (outst_q < w_eff) ? (w_eff - outst_q) : '0;
    fill_cnt    = (room < left_sat_q) ? room : left_sat_q;
    case (op_q)
      sws_pkg::OP_FILL:   plan_cnt = fill_cnt;
      sws_pkg::OP_RESEND: plan_cnt = outst_q;
      default:            plan_cnt = '0;
    endcase
    emit_inc    = (op_q == sws_pkg::OP_FILL) ? fill_cnt : '0;
    outst_after = {1'b0, outst_q} + {1'b0, emit_inc};
    all_sent    = left_le_q && (left_sat_q <= emit_inc);
    done_d      = done_q | (upd_q && all_sent &&
                  (mode_q == sws_pkg::MODE_CREDIT || outst_after == '0));
  end

  assign sts_o.out_free  = !out_vld_q || out_ready_i;
  assign sts_o.emit_last = (cnt_q <= CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= sws_pkg::MODE_CREDIT;
      win_q     <= sws_pkg::WIN_W'(1);
      frames_q  <= '0;
      base_q    <= '0;
      next_q    <= '0;
      done_q    <= 1'b0;
      started_q <= 1'b0;
      upd_q     <= 1'b0;
      op_q      <= sws_pkg::OP_STATUS;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sws_pkg::REG_MODE:   mode_q   <= cfg_wdata_i[sws_pkg::MODE_W-1:0];
          sws_pkg::REG_WINDOW: win_q    <= cfg_wdata_i[sws_pkg::WIN_W-1:0];
          sws_pkg::REG_FRAMES: frames_q <= cfg_wdata_i[sws_pkg::SEQ_W-1:0];
          default: ;
        endcase
      end

      if (cmd_i.retire) begin
        if (kind_q == sws_pkg::KIND_START) begin
          base_q    <= '0;
          next_q    <= '0;
          done_q    <= 1'b0;
          started_q <= 1'b1;
          upd_q     <= 1'b1;
          op_q      <= sws_pkg::OP_FILL;
        end else if (started_q && !done_q) begin
          upd_q <= 1'b1;
          if (kind_q == sws_pkg::KIND_ACK) begin
            if (!cumulative) begin
              if (outst_full != '0) begin
                base_q <= base_q + 1'b1;
              end
              op_q <= sws_pkg::OP_FILL;
            end else if ((ack_q - base_q) < outst_full) begin
              base_q <= ack_q + 1'b1;
              op_q   <= sws_pkg::OP_FILL;
            end else begin
              op_q <= sws_pkg::OP_STATUS;
            end
          end else begin
            op_q <= (mode_q != sws_pkg::MODE_CREDIT) ? sws_pkg::OP_RESEND
                                                     : sws_pkg::OP_STATUS;
          end
        end else begin
          upd_q <= 1'b0;
          op_q  <= sws_pkg::OP_STATUS;
        end
      end

      if (cmd_i.plan) begin
        done_q <= done_d;
      end

      if (cmd_i.emit && (cnt_q != '0) && (op_q == sws_pkg::OP_FILL)) begin
        next_q <= next_q + 1'b1;
      end

      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_kind_i;
      ack_q  <= in_ack_i;
    end
    if (cmd_i.measure) begin
      outst_q <= (outst_full > WM32) ? WM : outst_full[CW-1:0];
      if (next_q < frames_q) begin
        left_le_q  <= (left_full <= WM32);
        left_sat_q <= (left_full <= WM32) ? left_full[CW-1:0] : WM;
      end else begin
        left_le_q  <= 1'b1;
        left_sat_q <= '0;
      end
    end
    if (cmd_i.plan) begin
      cnt_q <= plan_cnt;
      seq_q <= (op_q == sws_pkg::OP_FILL) ? next_q : base_q;
    end
    if (cmd_i.emit) begin
      out_has_q  <= (cnt_q != '0);
      out_seq_q  <= (cnt_q != '0) ? seq_q : '0;
      out_rs_q   <= (cnt_q != '0) && (op_q == sws_pkg::OP_RESEND);
      out_fin_q  <= done_q;
      out_last_q <= (cnt_q <= CW'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        seq_q <= seq_q + 1'b1;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_seq_o   = out_seq_q;
  assign out_user_o  = {out_fin_q, out_rs_q, out_has_q};
  assign out_last_o  = out_last_q;

endmodule

>>> rtl/sliding_window_sender.sv
`timescale 1ns / 1ps
// Sliding window sender, top level: controller plus datapath.
// Depends on sws_pkg, sws_ctrl and sws_dp.
//
// Usage: program mode, window_size and frame_count on the cfg write port
// while idle, then send events on the slave stream (tuser = kind: start,
// ack or timeout; tdata = ack sequence). Each event yields a burst on the
// master stream: one transfer per frame to transmit, or one status
// transfer, with tlast on the final one of the burst.
// The first result follows the event transfer through the retire,
// measure and plan steps, then the output register load.
// Results leave at one per cycle while the receiver keeps tready high.
// The event channel is ready again once the last result is loaded and
// may take a new event while that result still waits.
// A stalled receiver holds the output register; the burst resumes when
// tready returns. Reset clears the config to its defaults, the window
// pointers, the done and started flags and the output valid flag.
module sliding_window_sender #(
  parameter int unsigned WIN_MAX = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sws_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [sws_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [sws_pkg::SEQ_W-1:0]         s_axis_tdata,   // [31:0] ack_seq
  input  logic [sws_pkg::KIND_W-1:0]        s_axis_tuser,   // [1:0] kind
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [sws_pkg::SEQ_W-1:0]         m_axis_tdata,   // [31:0] frame_seq
  output logic [sws_pkg::OUSR_W-1:0]        m_axis_tuser,   // [0] has_frame, [1] resend,
                                                            // [2] finished
  output logic                              m_axis_tlast
);

  sws_pkg::cmd_t cmd;
  sws_pkg::sts_t sts;

  sws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sws_dp #(
    .WIN_MAX (WIN_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_kind_i   (s_axis_tuser),
    .in_ack_i    (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_seq_o   (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> rtl/sws_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the sliding window sender, bound to the top level.
// Depends on sws_pkg for field widths.
module sws_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [sws_pkg::SEQ_W-1:0]  m_axis_tdata,
  input logic [sws_pkg::OUSR_W-1:0] m_axis_tuser,
  input logic                       m_axis_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a status result carries no frame and closes its burst
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tlast && !m_axis_tuser[1] && (m_axis_tdata == '0))
    else $error("malformed status result");

  // within a burst results follow back to back with the same flags
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tuser[0] &&
      (m_axis_tuser[2] == $past(m_axis_tuser[2])) &&
      (m_axis_tuser[1] == $past(m_axis_tuser[1])) &&
      (m_axis_tdata == $past(m_axis_tdata) + 1'b1))
    else $error("burst broken");

  // no new event while a burst is still open
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("event accepted mid-burst");

endmodule

bind sliding_window_sender sws_checker u_sws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for sliding_window_sender: directed and random event streams with an
// in-bench window predictor and a scoreboard checking every output transfer.
// Depends on sws_pkg and the sliding_window_sender rtl.
module tb;

  import sws_pkg::*;

  localparam int unsigned WIN_MAX   = 32;
  localparam int unsigned LIMIT     = 1_000_000;
  localparam int unsigned RAND_ITEMS = 380;

  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_CUMUL   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

  typedef struct {
    logic             has_frame;
    logic [SEQ_W-1:0] seq;
    logic             resend;
    logic             finished;
    logic             last;
  } tx_result_t;

  class window_scoreboard;
    logic [MODE_W-1:0] mode_r;
    logic [WIN_W-1:0]  window_r;
    logic [SEQ_W-1:0]  frames_r;
    logic [SEQ_W-1:0]  base_seq;
    logic [SEQ_W-1:0]  send_seq;
    bit                finished_r;
    bit                started_r;
    tx_result_t        burst_q[$];
    tx_result_t        expected_q[$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      mode_r     = MODE_CREDIT;
      window_r   = 1;
      frames_r   = '0;
      base_seq   = '0;
      send_seq   = '0;
      finished_r = 1'b0;
      started_r  = 1'b0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_MODE:   mode_r = data[MODE_W-1:0];
        REG_WINDOW: window_r = data[WIN_W-1:0];
        REG_FRAMES: frames_r = data[SEQ_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_window();
      int unsigned w;
      w = window_r;
      if (w < 1) w = 1;
      if (w > WIN_MAX) w = WIN_MAX;
      return w;
    endfunction

    function void fill_window();
      int unsigned w;
      w = eff_window();
      while (burst_q.size() < WIN_MAX && send_seq < frames_r &&
             (send_seq - base_seq) < w) begin
        burst_q.push_back('{1'b1, send_seq, 1'b0, 1'b0, 1'b0});
        send_seq++;
      end
    endfunction

    function void update_done();
      bit all_sent;
      all_sent = send_seq >= frames_r;
      if (mode_r == MODE_CREDIT) begin
        if (all_sent) finished_r = 1'b1;
      end else begin
        if (all_sent && base_seq == send_seq) finished_r = 1'b1;
      end
    endfunction

    function bit in_transfer();
      return started_r && !finished_r;
    endfunction

    function void note_event(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] ack);
      logic [SEQ_W-1:0] outstanding;
      logic [SEQ_W-1:0] s;
      burst_q.delete();
      if (kind == KIND_START) begin
        base_seq   = '0;
        send_seq   = '0;
        finished_r = 1'b0;
        started_r  = 1'b1;
        fill_window();
        update_done();
      end else if (in_transfer()) begin
        if (kind == KIND_ACK) begin
          outstanding = send_seq - base_seq;
          if (mode_r == MODE_CREDIT || mode_r == MODE_ANY) begin
            if (outstanding != 0) base_seq++;
            fill_window();
          end else if ((ack - base_seq) < outstanding) begin
            base_seq = ack + 1;
            fill_window();
          end
        end else if (mode_r != MODE_CREDIT) begin
          // timeout: go back to the oldest outstanding frame
          s = base_seq;
          while (s != send_seq && burst_q.size() < WIN_MAX) begin
            burst_q.push_back('{1'b1, s, 1'b1, 1'b0, 1'b0});
            s++;
          end
        end
        update_done();
      end
      if (burst_q.size() == 0) burst_q.push_back('{1'b0, '0, 1'b0, 1'b0, 1'b0});
      foreach (burst_q[k]) burst_q[k].finished = finished_r;
      burst_q[burst_q.size()-1].last = 1'b1;
      foreach (burst_q[k]) expected_q.push_back(burst_q[k]);
    endfunction

    task report(string field, logic [SEQ_W-1:0] got, logic [SEQ_W-1:0] want);
      errors++;
      $display("transfer %0d: %s is 0x%0h, predicted 0x%0h", checked, field, got, want);
    endtask

    task check_result(logic [SEQ_W-1:0] seq, logic [OUSR_W-1:0] user, logic last);
      tx_result_t w;
      checked++;
      if (expected_q.size() == 0) begin
        report("unexpected transfer, seq", seq, '0);
        return;
      end
      w = expected_q.pop_front();
      if (user[0] !== w.has_frame) report("has_frame", user[0], w.has_frame);
      if (seq !== w.seq)           report("frame_seq", seq, w.seq);
      if (user[1] !== w.resend)    report("resend", user[1], w.resend);
      if (user[2] !== w.finished)  report("finished", user[2], w.finished);
      if (last !== w.last)         report("tlast", last, w.last);
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]   cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [SEQ_W-1:0]   s_axis_tdata;
  logic [KIND_W-1:0]  s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [SEQ_W-1:0]   m_axis_tdata;
  logic [OUSR_W-1:0]  m_axis_tuser;
  logic               m_axis_tlast;

  window_scoreboard   sb;
  bit                 calm;
  int unsigned        cycles;
  int unsigned        sent;

  sliding_window_sender #(
    .WIN_MAX(WIN_MAX)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // receiver back-pressure
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (!calm) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk_i);
            m_axis_tready <= 1'b1;
          end
          2: repeat ($urandom_range(20, 80)) @(negedge clk_i);
          default: ;
        endcase
      end
    end
  end

  task automatic set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic configure(bit [2:0] which, logic [MODE_W-1:0] mode,
                           logic [WIN_W-1:0] win, logic [SEQ_W-1:0] frames);
    if (which[0]) set_reg(REG_MODE, CFG_W'(mode));
    if (which[1]) set_reg(REG_WINDOW, CFG_W'(win));
    if (which[2]) set_reg(REG_FRAMES, CFG_W'(frames));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_event(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] ack);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= ack;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_event(kind, ack);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic logic [SEQ_W-1:0] pick_ack();
    logic [SEQ_W-1:0] outstanding;
    outstanding = sb.send_seq - sb.base_seq;
    if (sb.mode_r >= MODE_CUMUL && outstanding != 0 && $urandom_range(0, 7) != 0) begin
      return sb.base_seq + SEQ_W'($urandom_range(0, outstanding - 1));
    end
    return $urandom;
  endfunction

  task automatic random_phase();
    logic [MODE_W-1:0] mode;
    logic [WIN_W-1:0]  win;
    logic [SEQ_W-1:0]  frames;
    int unsigned       r;
    mode = MODE_W'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       win = '0;
      1:       win = WIN_W'($urandom_range(33, 63));
      2:       win = WIN_W'(WIN_MAX);
      default: win = WIN_W'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 9))
      0:       frames = '0;
      1:       frames = '1;
      2:       frames = $urandom;
      default: frames = SEQ_W'($urandom_range(1, 48));
    endcase
    configure(3'($urandom_range(1, 7)), mode, win, frames);
    // now and then carry on with the old transfer under new settings
    if ($urandom_range(0, 4) != 0) send_event(KIND_START, $urandom);
    repeat ($urandom_range(6, 30)) begin
      r = $urandom_range(0, 99);
      if (r < 12)      send_event(KIND_TIMEOUT, $urandom);
      else if (r < 15) send_event(KIND_SPARE, $urandom);
      else if (r < 18) send_event(KIND_START, $urandom);
      else if (r < 26) send_event(KIND_ACK, $urandom);
      else             send_event(KIND_ACK, pick_ack());
      if (sent > RAND_ITEMS * 5 / 6) calm = 1'b1;
    end
    drain();
  endtask

  initial begin
    sb            = new();
    calm          = 1'b0;
    sent          = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_START;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: nothing started yet, empty transfer finishes at once
    send_event(KIND_ACK, '0);
    send_event(KIND_TIMEOUT, '1);
    send_event(KIND_START, '0);
    drain();

    // oversized window clamps, full-window burst and resend
    configure(3'b111, MODE_ANY, 6'd63, 32'd40);
    send_event(KIND_START, '0);
    send_event(KIND_TIMEOUT, '0);
    send_event(KIND_ACK, 32'hDEAD_BEEF);
    send_event(KIND_ACK, '0);
    send_event(KIND_SPARE, '0);
    drain();

    // cumulative acks: in window, duplicate, far outside, up to the newest
    configure(3'b111, MODE_CUMUL, 6'd4, 32'd10);
    send_event(KIND_START, '0);
    send_event(KIND_ACK, 32'd2);
    send_event(KIND_ACK, 32'd1);
    send_event(KIND_ACK, 32'hFFFF_FFFF);
    send_event(KIND_TIMEOUT, '0);
    send_event(KIND_ACK, 32'd6);
    send_event(KIND_ACK, 32'd9);
    drain();

    // credit mode, zero window clamps to one, timeout gives status only
    configure(3'b111, MODE_CREDIT, 6'd0, 32'd3);
    send_event(KIND_START, '0);
    send_event(KIND_TIMEOUT, '0);
    send_event(KIND_ACK, '0);
    send_event(KIND_ACK, '0);
    send_event(KIND_ACK, '0);
    send_event(KIND_ACK, '0);
    drain();

    // spare mode acts cumulative; huge frame count
    configure(3'b111, MODE_SPARE, 6'd5, 32'hFFFF_FFFF);
    send_event(KIND_START, '0);
    send_event(KIND_ACK, 32'h8000_0000);
    send_event(KIND_ACK, 32'd1);
    drain();

    while (sent < RAND_ITEMS) random_phase();

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
